FILE: sv/round_robin_thread_scheduler_join_defines.svh
// assertion macros for the round robin thread scheduler checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_JOIN_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_JOIN_DEFINES_SVH

// same-cycle implication
`define RRSJ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rrsj assertion failed");

// next-cycle implication
`define RRSJ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rrsj assertion failed");

`endif

FILE: sv/rrsj_pkg.sv
// shared types and constants of the round robin thread scheduler
// no dependencies; used by the memories, the top level and the checker
`default_nettype none

package rrsj_pkg;

  localparam int NumThreads = 8;
  localparam int TidW       = $clog2(NumThreads);
  localparam int CntW       = $clog2(NumThreads + 1);
  localparam int SumW       = $clog2(2 * NumThreads);

  localparam int OpW       = 3;
  localparam int CycW      = 32;
  localparam int JtidW     = 8;
  localparam int QuantW    = 16;
  localparam int InDataW   = 48;
  localparam int OutDataW  = 16;
  localparam int OutTidW   = 3;

  localparam logic [QuantW-1:0] QuantumReset = 16'd100;

  typedef enum logic [OpW-1:0] {
    OpTick   = 3'd0,
    OpCreate = 3'd1,
    OpExit   = 3'd2,
    OpJoin   = 3'd3,
    OpYield  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ModeReady   = 2'd0,
    ModeBlocked = 2'd1,
    ModeRunning = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [JtidW-1:0]  target;
  } tentry_t;

  typedef struct packed {
    logic            we;
    logic [TidW-1:0] waddr;
    logic [TidW-1:0] wdata;
    logic [TidW-1:0] raddr;
  } qmem_req_t;

  typedef struct packed {
    logic            we;
    logic [TidW-1:0] waddr;
    tentry_t         wdata;
    logic [TidW-1:0] raddr;
  } tmem_req_t;

  // thread table contents after reset
  function automatic tentry_t reset_entry(input logic [TidW-1:0] tid);
    tentry_t e;
    e.mode   = (tid == '0) ? ModeRunning : ModeReady;
    e.target = '0;
    return e;
  endfunction

endpackage

`default_nettype wire

FILE: sv/round_robin_thread_scheduler_join.sv
// channel   dir  width  contents
// cfg       in   16     quantum_cycles
// s_axis    in   48     operation, cycle_count, join_tid
// m_axis    out  16     running_tid, switched, created_tid, create_failed, deadlock
//
// one word at a time; a step that switches nothing goes from the front state straight to the output
// a switch walks the queue and tries threads in turn (none if the last one exits)
// each try is one run-queue read followed by one thread-table read
// a result waits in the output register; the next word is taken meanwhile
// a word that ends while a result still waits holds in its last cycle
// reset empties nothing: thread 0 runs alone, quantum is 100
//
// top level of the round robin thread scheduler with join
// depends on rrsj_pkg, rrsj_queue_mem and rrsj_thread_mem
`default_nettype none

module round_robin_thread_scheduler_join (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [rrsj_pkg::QuantW-1:0] cfg_data_i,    // quantum_cycles
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // [2:0] operation, [34:3] cycle_count, [42:35] join_tid, [47:43] zero
  input  wire logic [rrsj_pkg::InDataW-1:0] s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // [2:0] running_tid, [3] switched, [6:4] created_tid, [7] create_failed,
  // [8] deadlock, [15:9] zero
  output logic [rrsj_pkg::OutDataW-1:0]   m_axis_tdata
);
  import rrsj_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StFront = 3'd1;
  localparam logic [2:0] StSw0   = 3'd2;
  localparam logic [2:0] StWt    = 3'd3;
  localparam logic [2:0] StWe    = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [TidW-1:0]       head_q, head_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       k_q, k_d;
  logic [NumThreads-1:0] alive_q, alive_d;
  logic [CycW-1:0]       last_sw_q, last_sw_d;
  logic [QuantW-1:0]     quantum_q;
  logic                  out_valid_q, out_valid_d;
  logic [OutDataW-1:0]   out_data_q, out_data_d;

  logic [OpW-1:0]        op_q;
  logic [CycW-1:0]       cyc_q;
  logic [JtidW-1:0]      jt_q;
  logic                  switched_q, switched_d;
  logic                  dead_q, dead_d;
  logic                  failed_q, failed_d;
  logic [TidW-1:0]       created_q, created_d;

  qmem_req_t             qreq;
  tmem_req_t             treq;
  logic [TidW-1:0]       q_rd;
  tentry_t               t_rd;

  logic                  in_acc;
  logic [TidW-1:0]       head_inc;
  logic [SumW-1:0]       tail_sum;
  logic [TidW-1:0]       tail;
  logic [CycW-1:0]       elapsed;
  logic                  free_found;
  logic [TidW-1:0]       free_idx;
  logic                  jt_live;
  logic                  tgt_live;
  logic [OutTidW-1:0]    run_tid;

  rrsj_queue_mem u_queue_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (qreq),
    .rd_o   (q_rd)
  );

  rrsj_thread_mem u_thread_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (treq),
    .rd_o   (t_rd)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign head_inc = (head_q == TidW'(NumThreads - 1)) ? '0 : head_q + 1'b1;
  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail     = (tail_sum >= SumW'(NumThreads)) ? TidW'(tail_sum - SumW'(NumThreads))
                                                    : TidW'(tail_sum);
  assign elapsed  = cyc_q - last_sw_q;

  // out-of-range ids count as exited
  assign jt_live  = (32'(jt_q) < NumThreads) && alive_q[jt_q[TidW-1:0]];
  assign tgt_live = (32'(t_rd.target) < NumThreads) && alive_q[t_rd.target[TidW-1:0]];

  assign run_tid  = (count_q != '0) ? OutTidW'(q_rd) : '0;

  // lowest dead slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NumThreads - 1; i >= 0; i--) begin
      if (!alive_q[i]) begin
        free_found = 1'b1;
        free_idx   = TidW'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    k_d         = k_q;
    alive_d     = alive_q;
    last_sw_d   = last_sw_q;
    switched_d  = switched_q;
    dead_d      = dead_q;
    failed_d    = failed_q;
    created_d   = created_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    qreq        = '0;
    treq        = '0;

    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          switched_d = 1'b0;
          dead_d     = 1'b0;
          failed_d   = 1'b0;
          created_d  = '0;
          state_d    = StFront;
        end
      end
      StFront: begin
        state_d = StOut;
        unique case (op_q)
          OpTick: begin
            if ((count_q > CntW'(1)) && (elapsed >= CycW'(quantum_q))) begin
              switched_d = 1'b1;
              last_sw_d  = cyc_q;
              state_d    = StSw0;
            end
          end
          OpCreate: begin
            if (free_found) begin
              alive_d[free_idx] = 1'b1;
              treq.we           = 1'b1;
              treq.waddr        = free_idx;
              treq.wdata.mode   = ModeReady;
              treq.wdata.target = jt_q;
              if (count_q < CntW'(NumThreads)) begin
                qreq.we    = 1'b1;
                qreq.waddr = tail;
                qreq.wdata = free_idx;
                count_d    = count_q + 1'b1;
              end
              created_d = free_idx;
            end else begin
              failed_d = 1'b1;
            end
          end
          OpExit: begin
            if (count_q != '0) begin
              alive_d[q_rd] = 1'b0;
              switched_d    = 1'b1;
              state_d       = StSw0;
            end
          end
          OpJoin: begin
            if ((count_q != '0) && jt_live) begin
              // read of the same entry below sees this write
              treq.we           = 1'b1;
              treq.waddr        = q_rd;
              treq.wdata.mode   = ModeBlocked;
              treq.wdata.target = jt_q;
              switched_d        = 1'b1;
              state_d           = StSw0;
            end
          end
          OpYield: begin
            if (count_q != '0) begin
              switched_d = 1'b1;
              state_d    = StSw0;
            end
          end
          default: begin
            state_d = StOut;
          end
        endcase
      end
      StSw0: begin
        k_d = '0;
        if (!alive_q[q_rd]) begin
          // dead front leaves the queue, next entry is the first candidate
          head_d  = head_inc;
          count_d = count_q - 1'b1;
          state_d = (count_q == CntW'(1)) ? StOut : StWt;
        end else begin
          if (t_rd.mode == ModeRunning) begin
            treq.we           = 1'b1;
            treq.waddr        = q_rd;
            treq.wdata.mode   = ModeReady;
            treq.wdata.target = t_rd.target;
          end
          if (count_q >= CntW'(2)) begin
            qreq.we    = 1'b1;
            qreq.waddr = tail;
            qreq.wdata = q_rd;
            head_d     = head_inc;
          end
          state_d = StWt;
        end
      end
      StWt: begin
        state_d = StWe;
      end
      StWe: begin
        if ((t_rd.mode != ModeBlocked) || !tgt_live) begin
          treq.we           = 1'b1;
          treq.waddr        = q_rd;
          treq.wdata.mode   = ModeRunning;
          treq.wdata.target = t_rd.target;
          state_d           = StOut;
        end else begin
          if (count_q >= CntW'(2)) begin
            qreq.we    = 1'b1;
            qreq.waddr = tail;
            qreq.wdata = q_rd;
            head_d     = head_inc;
          end
          k_d = k_q + 1'b1;
          // a full lap of blocked threads leaves the order unchanged
          if ((k_q + 1'b1) == count_q) begin
            dead_d  = 1'b1;
            state_d = StOut;
          end else begin
            state_d = StWt;
          end
        end
      end
      StOut: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {7'b0, dead_q, failed_q, OutTidW'(created_q), switched_q, run_tid};
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // queue read follows the head so the front is ready in the cycle after the head moves
    qreq.raddr = head_d;
    treq.raddr = q_rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      count_q     <= CntW'(1);
      alive_q     <= NumThreads'(1);
      last_sw_q   <= '0;
      quantum_q   <= QuantumReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      alive_q     <= alive_d;
      last_sw_q   <= last_sw_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        quantum_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= s_axis_tdata[2:0];
      cyc_q <= s_axis_tdata[34:3];
      jt_q  <= s_axis_tdata[42:35];
    end
    k_q        <= k_d;
    switched_q <= switched_d;
    dead_q     <= dead_d;
    failed_q   <= failed_d;
    created_q  <= created_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire

FILE: sv/rrsj_queue_mem.sv
// run queue storage: one write and one read port, registered read
// depends on rrsj_pkg
`default_nettype none

module rrsj_queue_mem (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rrsj_pkg::qmem_req_t   req_i,
  output logic [rrsj_pkg::TidW-1:0]  rd_o
);
  import rrsj_pkg::*;

  logic [TidW-1:0]       mem_q [NumThreads];
  logic [NumThreads-1:0] valid_q;
  logic [TidW-1:0]       rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  // unwritten entries read as thread 0; same-entry write is forwarded
  always_ff @(posedge clk_i) begin
    if (req_i.we && (req_i.waddr == req_i.raddr)) begin
      rd_q <= req_i.wdata;
    end else if (valid_q[req_i.raddr]) begin
      rd_q <= mem_q[req_i.raddr];
    end else begin
      rd_q <= '0;
    end
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

FILE: sv/rrsj_thread_mem.sv
// per-thread table of mode and join target, registered read
// depends on rrsj_pkg
`default_nettype none

module rrsj_thread_mem (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rrsj_pkg::tmem_req_t req_i,
  output rrsj_pkg::tentry_t     rd_o
);
  import rrsj_pkg::*;

  tentry_t               mem_q [NumThreads];
  logic [NumThreads-1:0] valid_q;
  tentry_t               rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.we) begin
      valid_q[req_i.waddr] <= 1'b1;
    end
  end

  // entries never written read as their reset mode
  always_ff @(posedge clk_i) begin
    if (req_i.we && (req_i.waddr == req_i.raddr)) begin
      rd_q <= req_i.wdata;
    end else if (valid_q[req_i.raddr]) begin
      rd_q <= mem_q[req_i.raddr];
    end else begin
      rd_q <= reset_entry(req_i.raddr);
    end
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

FILE: sv/rrsj_checker.sv
// port-level checks on the round robin thread scheduler, bound to its top level
// depends on round_robin_thread_scheduler_join_defines.svh and rrsj_pkg
`default_nettype none
`include "round_robin_thread_scheduler_join_defines.svh"

module rrsj_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [rrsj_pkg::OutDataW-1:0]  m_axis_tdata
);
  import rrsj_pkg::*;

  logic out_stall;
  logic in_take;
  logic res_switched;
  logic res_failed;
  logic res_dead;
  logic [2:0] res_created;

  assign out_stall    = m_axis_tvalid && !m_axis_tready;
  assign in_take      = s_axis_tvalid && s_axis_tready;
  assign res_switched = m_axis_tdata[3];
  assign res_created  = m_axis_tdata[6:4];
  assign res_failed   = m_axis_tdata[7];
  assign res_dead     = m_axis_tdata[8];

  // a stalled result word holds
  `RRSJ_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // the block works on one word at a time
  `RRSJ_ASSERT_NEXT(a_busy_after_take, in_take, !s_axis_tready)

  // deadlock is only found by a switch walk
  `RRSJ_ASSERT_NOW(a_dead_switched, m_axis_tvalid && res_dead, res_switched)

  // failed create gives no slot and switches nothing
  `RRSJ_ASSERT_NOW(a_fail_clean, m_axis_tvalid && res_failed,
                   !res_switched && !res_dead && (res_created == 3'd0))

endmodule

bind round_robin_thread_scheduler_join rrsj_checker u_rrsj_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
